[rtl/dmae_pkg.sv]
// Shared types and constants for the multi-channel DMA address engine.
package dmae_pkg;

    localparam int CHANNELS     = 4;
    localparam int ADDR_W       = 32;
    localparam int COUNT_W      = 17;
    localparam int FLAGS_W      = 16;
    localparam int CTRL_SHIFT   = 16;
    localparam int START_LSB    = 12;
    localparam int F_ENABLE     = 15;
    localparam int F_WIDE       = 10;
    localparam int F_REPEAT     = 9;
    localparam int SRC_MODE_LSB = 7;
    localparam int DST_MODE_LSB = 5;

    typedef enum logic [1:0] {
        MODE_SETUP      = 2'd0,
        MODE_TRIGGER    = 2'd1,
        MODE_CTRL_WRITE = 2'd2,
        MODE_GRANT      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        AM_INC    = 2'd0,
        AM_DEC    = 2'd1,
        AM_FIXED  = 2'd2,
        AM_RELOAD = 2'd3
    } am_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [2:0]        channel;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
        logic [31:0]       control_word;
        logic [1:0]        start_type;
    } item_t;

    typedef struct packed {
        logic [1:0]        channel_served;
        logic [ADDR_W-1:0] read_address;
        logic [ADDR_W-1:0] write_address;
        logic              wide;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_slot_t;

endpackage

[rtl/dmae_in_stage.sv]
// Input register: holds one accepted item until the core consumes it.
module dmae_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  dmae_pkg::item_t item,
    input  logic           advance,
    output logic           held_valid,
    output dmae_pkg::item_t held_item
);

    logic            valid_reg;
    logic            valid_next;
    dmae_pkg::item_t item_reg;

    assign item_ready = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

[rtl/dmae_core.sv]
// Per-channel state, trigger logic, priority grant and address stepping.
module dmae_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dmae_pkg::item_t        item,
    input  logic                   advance,
    output dmae_pkg::result_slot_t slot
);

    typedef struct packed {
        logic [dmae_pkg::ADDR_W-1:0]  src;
        logic [dmae_pkg::ADDR_W-1:0]  dst;
        logic [dmae_pkg::COUNT_W-1:0] count;
        logic [dmae_pkg::FLAGS_W-1:0] flags;
        logic [dmae_pkg::ADDR_W-1:0]  src_copy;
        logic [dmae_pkg::ADDR_W-1:0]  dst_copy;
        logic [31:0]                  ctl_copy;
        logic                         pending;
    } chan_t;

    chan_t chan_reg  [dmae_pkg::CHANNELS];
    chan_t chan_next [dmae_pkg::CHANNELS];

    logic                          is_setup;
    logic                          is_trigger;
    logic                          is_ctrl;
    logic                          is_grant;
    logic                          ch_ok;
    logic                          fire_en;
    logic [1:0]                    fire_type;
    logic                          found;
    logic [dmae_pkg::CHANNELS-1:0] grant_oh;
    logic [dmae_pkg::CHANNELS-1:0] pend_vec;
    logic [dmae_pkg::CHANNELS-1:0] en_vec;

    function automatic logic [dmae_pkg::ADDR_W-1:0] step_addr
    (
        input logic [dmae_pkg::ADDR_W-1:0] a,
        input logic [1:0]                  m,
        input logic                        wide,
        input logic                        is_dest
    );
        logic [dmae_pkg::ADDR_W-1:0] size;
        logic [dmae_pkg::ADDR_W-1:0] r;
        size = wide ? dmae_pkg::ADDR_W'(4) : dmae_pkg::ADDR_W'(2);
        case (dmae_pkg::am_t'(m))
            dmae_pkg::AM_INC:    r = a + size;
            dmae_pkg::AM_DEC:    r = a - size;
            dmae_pkg::AM_RELOAD: r = is_dest ? a + size : a;
            default:             r = a;
        endcase
        return r;
    endfunction

    // Run complete: repeat reloads the count (and dest in reload mode), else disable.
    function automatic chan_t end_of_run(input chan_t s);
        chan_t r;
        r = s;
        r.pending = 1'b0;
        if (r.flags[dmae_pkg::F_REPEAT])
        begin
            r.count = r.ctl_copy[dmae_pkg::COUNT_W-1:0];
            if (dmae_pkg::am_t'(r.flags[dmae_pkg::DST_MODE_LSB +: 2]) == dmae_pkg::AM_RELOAD)
            begin
                r.dst = r.dst_copy;
            end
        end
        else
        begin
            r.flags[dmae_pkg::F_ENABLE] = 1'b0;
        end
        return r;
    endfunction

    assign is_setup   = dmae_pkg::mode_t'(item.mode) == dmae_pkg::MODE_SETUP;
    assign is_trigger = dmae_pkg::mode_t'(item.mode) == dmae_pkg::MODE_TRIGGER;
    assign is_ctrl    = dmae_pkg::mode_t'(item.mode) == dmae_pkg::MODE_CTRL_WRITE;
    assign is_grant   = dmae_pkg::mode_t'(item.mode) == dmae_pkg::MODE_GRANT;
    assign ch_ok      = {1'b0, item.channel} < 4'(dmae_pkg::CHANNELS);
    assign fire_en    = is_trigger || (is_setup && ch_ok);
    assign fire_type  = is_setup ? 2'b00 : item.start_type;

    // Lowest pending channel wins the grant.
    always_comb
    begin
        found    = 1'b0;
        grant_oh = '0;
        for (int c = 0; c < dmae_pkg::CHANNELS; c++)
        begin
            pend_vec[c] = chan_reg[c].pending;
            en_vec[c]   = chan_reg[c].flags[dmae_pkg::F_ENABLE];
            if (chan_reg[c].pending && !found)
            begin
                grant_oh[c] = 1'b1;
                found       = 1'b1;
            end
        end
    end

    always_comb
    begin
        slot.valid = is_grant && found;
        slot.data  = '0;
        for (int c = 0; c < dmae_pkg::CHANNELS; c++)
        begin
            if (grant_oh[c])
            begin
                slot.data.channel_served = 2'(c);
                slot.data.read_address   = chan_reg[c].src;
                slot.data.write_address  = chan_reg[c].dst;
                slot.data.wide           = chan_reg[c].flags[dmae_pkg::F_WIDE];
                slot.data.last           = chan_reg[c].count <= dmae_pkg::COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        chan_t t;
        logic  hit;
        logic  last_el;
        for (int c = 0; c < dmae_pkg::CHANNELS; c++)
        begin
            t       = chan_reg[c];
            hit     = {1'b0, item.channel} == 4'(c);
            last_el = t.count <= dmae_pkg::COUNT_W'(1);
            if (advance)
            begin
                if (is_setup && hit)
                begin
                    t.src_copy = item.source_address;
                    t.dst_copy = item.dest_address;
                    t.ctl_copy = item.control_word;
                    t.src      = item.source_address;
                    t.dst      = item.dest_address;
                    t.count    = item.control_word[dmae_pkg::COUNT_W-1:0];
                    t.flags    = item.control_word[dmae_pkg::CTRL_SHIFT +: dmae_pkg::FLAGS_W];
                    t.pending  = 1'b0;
                end
                if (is_ctrl && hit)
                begin
                    t.ctl_copy = item.control_word;
                end
                if (is_grant && grant_oh[c])
                begin
                    t.dst   = step_addr(t.dst, t.flags[dmae_pkg::DST_MODE_LSB +: 2],
                                        t.flags[dmae_pkg::F_WIDE], 1'b1);
                    t.src   = step_addr(t.src, t.flags[dmae_pkg::SRC_MODE_LSB +: 2],
                                        t.flags[dmae_pkg::F_WIDE], 1'b0);
                    t.count = t.count - dmae_pkg::COUNT_W'(1);
                    if (last_el)
                    begin
                        t.count = '0;
                        t = end_of_run(t);
                    end
                end
                if (fire_en)
                begin
                    if (!t.ctl_copy[dmae_pkg::CTRL_SHIFT + dmae_pkg::F_ENABLE])
                    begin
                        t.flags[dmae_pkg::F_ENABLE] = 1'b0;
                        t.pending = 1'b0;
                    end
                    if (t.flags[dmae_pkg::F_ENABLE] &&
                        t.flags[dmae_pkg::START_LSB +: 2] == fire_type)
                    begin
                        if (t.count == '0)
                        begin
                            t = end_of_run(t);
                        end
                        else
                        begin
                            t.pending = 1'b1;
                        end
                    end
                end
            end
            chan_next[c] = t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < dmae_pkg::CHANNELS; c++)
            begin
                chan_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < dmae_pkg::CHANNELS; c++)
            begin
                chan_reg[c] <= chan_next[c];
            end
        end
    end

    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant_oh))
        else $error("grant select not one-hot");

    a_result_only_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        slot.valid |-> (is_grant && (pend_vec != '0)))
        else $error("result without grant or pending channel");

    a_pending_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_vec & ~en_vec) == '0)
        else $error("pending channel is not enabled");

endmodule

[rtl/dmae_out_stage.sv]
// Result register: holds one transfer descriptor until the sink takes it.
module dmae_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  dmae_pkg::result_slot_t slot,
    output logic                   result_valid,
    input  logic                   result_ready,
    output dmae_pkg::result_t      result
);

    logic              valid_reg;
    logic              valid_next;
    dmae_pkg::result_t data_reg;

    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = slot.valid;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && slot.valid)
        begin
            data_reg <= slot.data;
        end
    end

endmodule

[rtl/multi_channel_dma_address_engine_top.sv]
// Top level of the four-channel DMA address engine.
//
//   channel   dir   handshake                    payload
//   item      in    item_valid / item_ready      dmae_pkg::item_t
//   result    out   result_valid / result_ready  dmae_pkg::result_t
//
// One item per cycle while the sink does not stall: the input register
// feeds one pass of channel logic into the result register, where a
// grant's transfer appears. Setup, trigger and control writes add none.
// Reset clears all channel state, pending bits and both stage valids.
// A result held by a stalled sink holds the input register; the item port
// still takes a transfer while the input register is empty.
module multi_channel_dma_address_engine_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  dmae_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output dmae_pkg::result_t result
);

    logic                   held_valid;
    dmae_pkg::item_t        held_item;
    logic                   advance;
    dmae_pkg::result_slot_t slot;

    assign advance = held_valid && (!result_valid || result_ready);

    dmae_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    dmae_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (held_item),
        .advance (advance),
        .slot    (slot)
    );

    dmae_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .slot         (slot),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
